// ----- src/mvt_pkg.sv -----
`default_nettype none
package mvt_pkg;

  // Fixed-point format and sizes
  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;
  localparam int PAIR_W     = 2 * DATA_W;
  localparam int NUM_DIM    = 4;
  localparam int NUM_ENTRY  = NUM_DIM * NUM_DIM;
  localparam int NUM_PAIRS  = NUM_ENTRY / 2;
  localparam int CFG_ADDR_W = 4;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int PSUM_W     = PROD_W + 1;
  localparam int SUM_W      = PROD_W + 2;

  // Fixed-point 1.0 in a register half, and the register reset image
  localparam logic [PAIR_W-1:0] ONE_LO = PAIR_W'(1) << FRAC_BITS;
  localparam logic [PAIR_W-1:0] ONE_HI = ONE_LO << DATA_W;

  typedef logic [PAIR_W-1:0] pair_arr_t [NUM_PAIRS];

  localparam pair_arr_t PAIR_RESET = '{
    ONE_LO, '0, ONE_HI, '0, ONE_LO, '0, '0, ONE_HI
  };

  // Saturation limits
  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Per-stage load enables shared by all lanes
  typedef struct packed {
    logic en_mul;
    logic en_add;
    logic en_out;
  } pipe_ctrl_t;

endpackage
`default_nettype wire

// ----- src/mvt_lane.sv -----
`default_nettype none
// One output component: four products, adder tree, shift and saturate.
module mvt_lane (
  input  logic                              clk,
  input  mvt_pkg::pipe_ctrl_t               ctrl,
  input  logic signed [mvt_pkg::DATA_W-1:0] vec [mvt_pkg::NUM_DIM],
  input  logic signed [mvt_pkg::DATA_W-1:0] coef [mvt_pkg::NUM_DIM],
  output logic        [mvt_pkg::DATA_W-1:0] res,
  output logic                              sat
);

  logic signed [mvt_pkg::PROD_W-1:0] prod [mvt_pkg::NUM_DIM];
  logic signed [mvt_pkg::PSUM_W-1:0] psum [mvt_pkg::NUM_DIM/2];
  logic signed [mvt_pkg::SUM_W-1:0]  sum;
  logic signed [mvt_pkg::SUM_W-1:0]  shifted;
  logic                              over_hi;
  logic                              over_lo;

  // Stage 1: exact products
  always_ff @(posedge clk) begin
    if (ctrl.en_mul) begin
      for (int j = 0; j < mvt_pkg::NUM_DIM; j++) begin
        prod[j] <= coef[j] * vec[j];
      end
    end
  end

  // Stage 2: pairwise sums
  always_ff @(posedge clk) begin
    if (ctrl.en_add) begin
      for (int k = 0; k < mvt_pkg::NUM_DIM/2; k++) begin
        psum[k] <= mvt_pkg::PSUM_W'(prod[2*k]) + mvt_pkg::PSUM_W'(prod[2*k+1]);
      end
    end
  end

  // Stage 3: final sum, floor shift, clip to 32 bits
  always_comb begin
    sum     = mvt_pkg::SUM_W'(psum[0]) + mvt_pkg::SUM_W'(psum[1]);
    shifted = sum >>> mvt_pkg::FRAC_BITS;
    over_hi = !shifted[mvt_pkg::SUM_W-1] && (|shifted[mvt_pkg::SUM_W-2:mvt_pkg::DATA_W-1]);
    over_lo = shifted[mvt_pkg::SUM_W-1] && !(&shifted[mvt_pkg::SUM_W-2:mvt_pkg::DATA_W-1]);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en_out) begin
      priority if (over_hi) begin
        res <= mvt_pkg::SAT_MAX;
      end else if (over_lo) begin
        res <= mvt_pkg::SAT_MIN;
      end else begin
        res <= shifted[mvt_pkg::DATA_W-1:0];
      end
      sat <= over_hi || over_lo;
    end
  end

endmodule
`default_nettype wire

// ----- src/matrix_vector_transform_core.sv -----
`default_nettype none
// 4x4 matrix times homogeneous vector, signed Q16.16, saturated outputs.
// An input transaction reaches out_valid through the multiply, pair add and
// final add with shift and clip stages, each registered; the 16 parallel multipliers set stage one.
// Throughput: one vector per cycle; a stalled output holds the pipeline.
// Reset: clears all stage valid bits and loads the matrix reset image.
module matrix_vector_transform_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [mvt_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [mvt_pkg::PAIR_W-1:0]            cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [mvt_pkg::DATA_W-1:0]     in_x,
  input  logic signed [mvt_pkg::DATA_W-1:0]     in_y,
  input  logic signed [mvt_pkg::DATA_W-1:0]     in_z,
  input  logic signed [mvt_pkg::DATA_W-1:0]     in_w,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [mvt_pkg::DATA_W-1:0]     out_x,
  output logic signed [mvt_pkg::DATA_W-1:0]     out_y,
  output logic signed [mvt_pkg::DATA_W-1:0]     out_z,
  output logic signed [mvt_pkg::DATA_W-1:0]     out_w,
  output logic                                  saturated
);

  mvt_pkg::pair_arr_t                matrix_pair;
  logic signed [mvt_pkg::DATA_W-1:0] entry [mvt_pkg::NUM_ENTRY];
  logic signed [mvt_pkg::DATA_W-1:0] vec [mvt_pkg::NUM_DIM];
  logic        [mvt_pkg::DATA_W-1:0] res [mvt_pkg::NUM_DIM];
  logic        [mvt_pkg::NUM_DIM-1:0] sat;
  logic                              v_mul;
  logic                              v_add;
  mvt_pkg::pipe_ctrl_t               ctrl;

  // Matrix registers; writes past the last pair are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_pair <= mvt_pkg::PAIR_RESET;
    end else if (cfg_wr_en && (cfg_addr < mvt_pkg::CFG_ADDR_W'(mvt_pkg::NUM_PAIRS))) begin
      matrix_pair[cfg_addr[$clog2(mvt_pkg::NUM_PAIRS)-1:0]] <= cfg_data;
    end
  end

  // Unpack pairs into column-major entries
  for (genvar e = 0; e < mvt_pkg::NUM_ENTRY; e++) begin : g_entry
    assign entry[e] = matrix_pair[e/2][(e%2)*mvt_pkg::DATA_W +: mvt_pkg::DATA_W];
  end

  assign vec[0] = in_x;
  assign vec[1] = in_y;
  assign vec[2] = in_z;
  assign vec[3] = in_w;

  // Stage enables: a stage loads when empty or when its successor moves
  always_comb begin
    ctrl.en_out = !out_valid || out_ready;
    ctrl.en_add = !v_add || ctrl.en_out;
    ctrl.en_mul = !v_mul || ctrl.en_add;
  end

  assign in_ready = ctrl.en_mul;

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v_mul     <= 1'b0;
      v_add     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.en_mul) v_mul     <= in_valid;
      if (ctrl.en_add) v_add     <= v_mul;
      if (ctrl.en_out) out_valid <= v_add;
    end
  end

  // One lane per output component, column entries m[4j+i]
  for (genvar i = 0; i < mvt_pkg::NUM_DIM; i++) begin : g_lane
    logic signed [mvt_pkg::DATA_W-1:0] coef [mvt_pkg::NUM_DIM];
    for (genvar j = 0; j < mvt_pkg::NUM_DIM; j++) begin : g_coef
      assign coef[j] = entry[mvt_pkg::NUM_DIM*j + i];
    end
    mvt_lane u_lane (
      .clk  (clk),
      .ctrl (ctrl),
      .vec  (vec),
      .coef (coef),
      .res  (res[i]),
      .sat  (sat[i])
    );
  end

  assign out_x     = res[0];
  assign out_y     = res[1];
  assign out_z     = res[2];
  assign out_w     = res[3];
  assign saturated = |sat;

endmodule
`default_nettype wire

// ----- src/mvt_checker.sv -----
`default_nettype none
module mvt_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [mvt_pkg::DATA_W-1:0] out_x,
  input  logic signed [mvt_pkg::DATA_W-1:0] out_y,
  input  logic signed [mvt_pkg::DATA_W-1:0] out_z,
  input  logic signed [mvt_pkg::DATA_W-1:0] out_w,
  input  logic                              saturated
);

  // Held result stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_z) && $stable(out_w) && $stable(saturated))
    else $error("stalled result changed");

  // Saturation flag implies some component sits at a limit
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      (out_x == mvt_pkg::SAT_MAX) || (out_x == mvt_pkg::SAT_MIN) ||
      (out_y == mvt_pkg::SAT_MAX) || (out_y == mvt_pkg::SAT_MIN) ||
      (out_z == mvt_pkg::SAT_MAX) || (out_z == mvt_pkg::SAT_MIN) ||
      (out_w == mvt_pkg::SAT_MAX) || (out_w == mvt_pkg::SAT_MIN))
    else $error("saturated set with no clipped component");

  // Back pressure only comes from a waiting result
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // An accepted transaction shows out_valid once it has passed the multiply, pair add and output registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> ##3 out_valid)
    else $error("no result three cycles after input transaction");

endmodule

bind matrix_vector_transform_core mvt_checker u_mvt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_x     (out_x),
  .out_y     (out_y),
  .out_z     (out_z),
  .out_w     (out_w),
  .saturated (saturated)
);
`default_nettype wire
